// ----- design/drum_voice_allocator_with_choke_defines.svh -----
`ifndef DRUM_VOICE_ALLOCATOR_WITH_CHOKE_DEFINES_SVH
`define DRUM_VOICE_ALLOCATOR_WITH_CHOKE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define DVAC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define DVAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/dvac_pkg.sv -----
`default_nettype none

package dvac_pkg;

    localparam int VOICES_DEF = 16;
    localparam int PADS_DEF   = 16;
    localparam int STAMP_W    = 64;

    localparam logic [31:0] SEED_GOLDEN = 32'h9E37_79B9;
    localparam logic [31:0] SEED_MIX    = 32'h85EB_CA6B;

    localparam logic [63:0] CHOKE_MAP_RST = 64'h0000_0000_1100_0000;
    localparam logic [6:0]  FIRST_KEY_RST = 7'd36;

    // Configuration register indexes
    localparam logic CFG_CHOKE_MAP = 1'b0;
    localparam logic CFG_FIRST_KEY = 1'b1;

    typedef enum logic [1:0] {
        MODE_NOTE_ON = 2'd0,
        MODE_RETIRE  = 2'd1,
        MODE_ALL_OFF = 2'd2,
        MODE_UNUSED  = 2'd3
    } t_mode;

    // Commit command broadcast to every voice cell
    typedef struct packed {
        logic               commit_note;
        logic               commit_retire;
        logic               commit_all_off;
        logic [3:0]         pad;
        logic [3:0]         group;
        logic [STAMP_W-1:0] stamp;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ----- design/dvac_cell.sv -----
`default_nettype none

module dvac_cell #(
    parameter int VOICES = dvac_pkg::VOICES_DEF,
    parameter int IDX    = 0
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire dvac_pkg::t_cell_cmd                 i_cmd,
    input  wire logic                                i_sel,
    output logic                                     o_choke,
    input  wire logic                                i_free_found,
    input  wire logic [$clog2(VOICES)-1:0]           i_free_idx,
    input  wire logic [dvac_pkg::STAMP_W-1:0]        i_best_stamp,
    input  wire logic [$clog2(VOICES)-1:0]           i_best_idx,
    output logic                                     o_free_found,
    output logic [$clog2(VOICES)-1:0]                o_free_idx,
    output logic [dvac_pkg::STAMP_W-1:0]             o_best_stamp,
    output logic [$clog2(VOICES)-1:0]                o_best_idx
);
    import dvac_pkg::*;

    localparam int IW = $clog2(VOICES);
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic               r_active;
    logic               r_fading;
    logic [3:0]         r_pad;
    logic [3:0]         r_group;
    logic [STAMP_W-1:0] r_stamp;

    logic               r_free_found;
    logic [IW-1:0]      r_free_idx;
    logic [STAMP_W-1:0] r_best_stamp;
    logic [IW-1:0]      r_best_idx;

    // Voice is cut by the new hit: same pad, or same nonzero choke group
    assign o_choke = r_active && !r_fading &&
                     ((r_pad == i_cmd.pad) || ((i_cmd.group != 4'd0) && (r_group == i_cmd.group)));

    // Voice state: allocate, choke, retire, clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_fading <= 1'b0;
        end else if (i_cmd.commit_all_off) begin
            r_active <= 1'b0;
            r_fading <= 1'b0;
        end else if (i_cmd.commit_retire && i_sel) begin
            r_active <= 1'b0;
            r_fading <= 1'b0;
        end else if (i_cmd.commit_note) begin
            if (i_sel) begin
                r_active <= 1'b1;
                r_fading <= 1'b0;
                r_pad    <= i_cmd.pad;
                r_group  <= i_cmd.group;
                r_stamp  <= i_cmd.stamp;
            end else if (o_choke) begin
                r_fading <= 1'b1;
            end
        end
    end

    // Scan chain: first free slot and oldest stamp, handed on every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_found <= 1'b0;
        end else begin
            r_free_found <= i_free_found || !r_active;
        end
        r_free_idx <= i_free_found ? i_free_idx : MY_IDX;
        if (r_stamp < i_best_stamp) begin
            r_best_stamp <= r_stamp;
            r_best_idx   <= MY_IDX;
        end else begin
            r_best_stamp <= i_best_stamp;
            r_best_idx   <= i_best_idx;
        end
    end

    assign o_free_found = r_free_found;
    assign o_free_idx   = r_free_idx;
    assign o_best_stamp = r_best_stamp;
    assign o_best_idx   = r_best_idx;

endmodule

`default_nettype wire

// ----- design/drum_voice_allocator_with_choke.sv -----
// Drum voice allocator with choke groups.
// Input channel: i_in_valid / o_in_stall carry one word (mode, note number,
// velocity, voice index). Output channel: o_out_valid / i_out_stall carry one
// result word per input word. A word moves at a clock edge with valid high
// and stall low. Config: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 choke map, 1 first key); the user must do this only while the block is
// idle, which the block itself does not enforce. One word is worked on at a
// time. A note-on that maps to a pad runs a scan down the row of VOICES voice
// cells (one cell per cycle, each comparing one stored stamp); the result is
// registered at commit once the scan ends; the block then returns to idle
// for the next word. Retire, all-off, unused modes and rejected notes skip
// the scan and give an all-zero result.
// The result sits in an output register; a new word is accepted while it
// waits, but the following commit holds until the receiver takes it.
// Reset (synchronous, active low) frees all voices, zeroes the hit counter
// and restores both configuration registers.
`default_nettype none

module drum_voice_allocator_with_choke #(
    parameter int VOICES = dvac_pkg::VOICES_DEF,
    parameter int PADS   = dvac_pkg::PADS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [6:0]  i_note_number,
    input  wire logic [6:0]  i_velocity,
    input  wire logic [3:0]  i_voice_index,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_accepted,
    output logic [3:0]       o_voice_slot,
    output logic             o_was_stolen,
    output logic [15:0]      o_choke_mask,
    output logic [31:0]      o_noise_seed,
    output logic [3:0]       o_pad_index,
    output logic [6:0]       o_voice_velocity
);
    import dvac_pkg::*;

    localparam int IW = $clog2(VOICES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state             r_state;
    logic [63:0]        r_choke_map;
    logic [6:0]         r_first_key;
    logic [STAMP_W-1:0] r_hit_counter;
    t_mode              r_mode;
    logic               r_ok;
    logic [3:0]         r_pad;
    logic [3:0]         r_group;
    logic [6:0]         r_velocity;
    logic [3:0]         r_vidx;
    logic [IW-1:0]      r_cnt;
    logic [31:0]        r_prod_hit;
    logic [31:0]        r_prod_pad;

    logic               r_out_valid;
    logic               r_accepted;
    logic [3:0]         r_voice_slot;
    logic               r_was_stolen;
    logic [15:0]        r_choke_mask;
    logic [31:0]        r_noise_seed;
    logic [3:0]         r_pad_index;
    logic [6:0]         r_voice_velocity;

    logic [7:0]         w_diff;
    logic               w_note_ok;
    logic [3:0]         w_group;
    logic               w_in_take;
    logic               w_commit;
    t_cell_cmd          w_cmd;

    logic               w_free_found [0:VOICES];
    logic [IW-1:0]      w_free_idx   [0:VOICES];
    logic [STAMP_W-1:0] w_best_stamp [0:VOICES];
    logic [IW-1:0]      w_best_idx   [0:VOICES];
    logic [VOICES-1:0]  w_choke;
    logic [VOICES-1:0]  w_sel;
    logic [IW-1:0]      w_slot;
    logic [VOICES-1:0]  w_mask;
    logic [VOICES+15:0] w_mask_ext;
    logic [IW+3:0]      w_slot_ext;

    // Map note to pad and look up its choke group
    assign w_diff    = {1'b0, i_note_number} - {1'b0, r_first_key};
    assign w_note_ok = (t_mode'(i_mode) == MODE_NOTE_ON) && !w_diff[7] &&
                       (w_diff[6:0] < 7'(PADS));
    assign w_group   = r_choke_map[{w_diff[3:0], 2'b00} +: 4];

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_take  = i_in_valid && (r_state == ST_IDLE);
    assign w_commit   = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

    // Commit command to the cells
    always_comb begin
        w_cmd.commit_note    = w_commit && r_ok;
        w_cmd.commit_retire  = w_commit && (r_mode == MODE_RETIRE);
        w_cmd.commit_all_off = w_commit && (r_mode == MODE_ALL_OFF);
        w_cmd.pad            = r_pad;
        w_cmd.group          = r_group;
        w_cmd.stamp          = r_hit_counter;
    end

    // Head of the scan chain
    assign w_free_found[0] = 1'b0;
    assign w_free_idx[0]   = '0;
    assign w_best_stamp[0] = '1;
    assign w_best_idx[0]   = '0;

    assign w_slot = w_free_found[VOICES] ? w_free_idx[VOICES] : w_best_idx[VOICES];

    for (genvar g = 0; g < VOICES; g++) begin : g_cell
        assign w_sel[g] = r_ok ? (w_slot == IW'(g)) : (7'(r_vidx) == 7'(g));

        dvac_cell #(
            .VOICES (VOICES),
            .IDX    (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_sel        (w_sel[g]),
            .o_choke      (w_choke[g]),
            .i_free_found (w_free_found[g]),
            .i_free_idx   (w_free_idx[g]),
            .i_best_stamp (w_best_stamp[g]),
            .i_best_idx   (w_best_idx[g]),
            .o_free_found (w_free_found[g+1]),
            .o_free_idx   (w_free_idx[g+1]),
            .o_best_stamp (w_best_stamp[g+1]),
            .o_best_idx   (w_best_idx[g+1])
        );
    end

    // Drop the allocated slot from the fade mask
    assign w_mask     = w_choke & ~w_sel;
    assign w_mask_ext = {16'b0, w_mask};
    assign w_slot_ext = {4'b0, w_slot};

    // Sequencer, configuration and result register
    always_ff @(posedge i_clk) begin
        r_prod_hit <= r_hit_counter[31:0] * SEED_GOLDEN;
        r_prod_pad <= 32'(r_pad) * SEED_MIX;
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
            r_hit_counter <= '0;
            r_choke_map   <= CHOKE_MAP_RST;
            r_first_key   <= FIRST_KEY_RST;
            r_ok          <= 1'b0;
            r_mode        <= MODE_UNUSED;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CHOKE_MAP: r_choke_map <= i_cfg_data;
                    CFG_FIRST_KEY: r_first_key <= i_cfg_data[6:0];
                endcase
            end

            // Raise valid on commit, drop it once the word is taken
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_take) begin
                        r_mode     <= t_mode'(i_mode);
                        r_ok       <= w_note_ok;
                        r_pad      <= w_diff[3:0];
                        r_group    <= w_group;
                        r_velocity <= i_velocity;
                        r_vidx     <= i_voice_index;
                        r_cnt      <= '0;
                        r_state    <= w_note_ok ? ST_SCAN : ST_DONE;
                    end
                end
                ST_SCAN: begin
                    // advance the stamp on the first scan cycle
                    if (r_cnt == '0) begin
                        r_hit_counter <= r_hit_counter + 1'b1;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == IW'(VOICES - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_commit) begin
                        r_state <= ST_IDLE;
                        if (r_ok) begin
                            r_accepted       <= 1'b1;
                            r_voice_slot     <= w_slot_ext[3:0];
                            r_was_stolen     <= !w_free_found[VOICES];
                            r_choke_mask     <= w_mask_ext[15:0];
                            r_noise_seed     <= r_prod_hit + r_prod_pad + 32'd1;
                            r_pad_index      <= r_pad;
                            r_voice_velocity <= r_velocity;
                        end else begin
                            r_accepted       <= 1'b0;
                            r_voice_slot     <= '0;
                            r_was_stolen     <= 1'b0;
                            r_choke_mask     <= '0;
                            r_noise_seed     <= '0;
                            r_pad_index      <= '0;
                            r_voice_velocity <= '0;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_accepted       = r_accepted;
    assign o_voice_slot     = r_voice_slot;
    assign o_was_stolen     = r_was_stolen;
    assign o_choke_mask     = r_choke_mask;
    assign o_noise_seed     = r_noise_seed;
    assign o_pad_index      = r_pad_index;
    assign o_voice_velocity = r_voice_velocity;

endmodule

`default_nettype wire

// ----- design/dvac_checker.sv -----
`default_nettype none
`include "drum_voice_allocator_with_choke_defines.svh"

module dvac_checker #(
    parameter int PADS   = dvac_pkg::PADS_DEF
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_accepted,
    input wire logic        o_was_stolen,
    input wire logic [15:0] o_choke_mask,
    input wire logic [31:0] o_noise_seed,
    input wire logic [3:0]  o_pad_index,
    input wire logic [6:0]  o_voice_velocity
);

    // Hold a stalled result word
    `DVAC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_noise_seed) && $stable(o_choke_mask), "result word changed under stall")

    // One word in flight: stall right after an accepted input word
    `DVAC_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input taken while a word is in flight")

    // A word that took no voice carries zeros
    `DVAC_ASSERT_NOW(a_reject_zero, i_clk, i_rst_n, o_out_valid && !o_accepted, (o_choke_mask == 16'd0) && (o_noise_seed == 32'd0) && !o_was_stolen && (o_voice_velocity == 7'd0), "rejected word has nonzero fields")

    // Pad index stays inside the pad range
    `DVAC_ASSERT_NOW(a_pad_range, i_clk, i_rst_n, o_out_valid && o_accepted, ({1'b0, o_pad_index} < 5'(PADS)), "pad index out of range")

endmodule

bind drum_voice_allocator_with_choke dvac_checker #(
    .PADS   (PADS)
) u_dvac_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_accepted       (o_accepted),
    .o_was_stolen     (o_was_stolen),
    .o_choke_mask     (o_choke_mask),
    .o_noise_seed     (o_noise_seed),
    .o_pad_index      (o_pad_index),
    .o_voice_velocity (o_voice_velocity)
);

`default_nettype wire
